[rtl/tps_pkg.sv]
// Package for the trajectory playback sequencer.
// Holds command, run state, reply and sequencer state types and fixed-point constants.
// No dependencies.
package tps_pkg;

    localparam int MAX_POINTS = 65536;
    localparam int POINT_W    = 17;
    localparam int INDEX_W    = 16;
    localparam int FACTOR_W   = 18;
    localparam int ACC_W      = 33;
    localparam int RAMP_W     = 16;
    localparam int JOINT_W    = 4;
    localparam int PCT_W      = 8;
    localparam int STEP_W     = 5;

    localparam logic [FACTOR_W-1:0] ONE_FACTOR     = 18'h10000;
    localparam logic [FACTOR_W-1:0] FACTOR_MAX     = 18'd167116;
    localparam logic [RAMP_W-1:0]   SPEED_DIVISOR  = 16'd100;
    localparam logic [RAMP_W-1:0]   SLOWDOWN_RESET = 16'd500;
    localparam logic [JOINT_W-1:0]  JOINTS_RESET   = 4'd6;
    localparam logic [STEP_W-1:0]   MUL_LAST_STEP  = 5'd15;
    localparam logic [STEP_W-1:0]   DIV_LAST_STEP  = 5'd17;

    typedef enum logic [3:0] {
        MODE_TICK     = 4'd0,
        MODE_START    = 4'd1,
        MODE_STOP     = 4'd2,
        MODE_RESUME   = 4'd3,
        MODE_PAUSE    = 4'd4,
        MODE_EXECUTE  = 4'd5,
        MODE_SPEED    = 4'd6,
        MODE_SECURITY = 4'd7,
        MODE_LOAD     = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        RUN_STOPPED  = 2'd0,
        RUN_RESUMING = 2'd1,
        RUN_PAUSING  = 2'd2,
        RUN_RUNNING  = 2'd3
    } run_t;

    typedef enum logic [2:0] {
        REPLY_OK             = 3'd0,
        REPLY_RESUME_REFUSED = 3'd1,
        REPLY_PAUSE_REFUSED  = 3'd2,
        REPLY_NO_TRAJECTORY  = 3'd3,
        REPLY_UNKNOWN        = 3'd4,
        REPLY_NOT_IN_PLACE   = 3'd5
    } reply_t;

    typedef enum logic [0:0] {
        CFG_SLOWDOWN = 1'b0,
        CFG_JOINTS   = 1'b1
    } cfg_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_APPLY,
        SEQ_TICK_END,
        SEQ_EMIT
    } seq_state_t;

endpackage

[rtl/trajectory_playback_sequencer_core.sv]
// Trajectory playback sequencer: command decode, point accumulator and ramp unit.
// Ramp and speed values come from a bit-serial shift-add multiplier and restoring divider.
// Depends on tps_pkg.
// A tick that recomputes a ramp factor runs 16 multiply and 18 divide steps, and set
// speed runs 18 divide steps; other ticks and other commands use neither unit.
// A result is registered in the emit state; the next item can be taken in the cycle after.
// Reset (rst_n low, asynchronous): run state running, factor 0, saved factor 1.0,
// slowdown_ticks 500, joint_total 6, one active point, no loaded trajectory, no result.
module trajectory_playback_sequencer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [3:0]                     mode,
    input  logic [tps_pkg::POINT_W-1:0]    point_count,
    input  logic [tps_pkg::JOINT_W-1:0]    joint_count,
    input  logic [tps_pkg::PCT_W-1:0]      speed_percent,
    input  logic                           start_in_place,
    input  logic                           joint_fault,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [1:0]                     run_state,
    output logic [tps_pkg::FACTOR_W-1:0]   speed_factor,
    output logic [tps_pkg::INDEX_W-1:0]    point_index,
    output logic [2:0]                     reply_code,
    output logic                           drive_enable,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic [tps_pkg::RAMP_W-1:0]     cfg_data
);

    tps_pkg::seq_state_t state_reg, state_next;
    tps_pkg::run_t       run_reg, run_next;
    tps_pkg::reply_t     reply_reg, reply_next;

    logic [tps_pkg::FACTOR_W-1:0] factor_reg, factor_next;
    logic [tps_pkg::FACTOR_W-1:0] saved_reg, saved_next;
    logic [tps_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [tps_pkg::RAMP_W-1:0]   ramp_reg, ramp_next;
    logic [tps_pkg::POINT_W-1:0]  active_len_reg, active_len_next;
    logic [tps_pkg::POINT_W-1:0]  loaded_len_reg, loaded_len_next;
    logic [tps_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [tps_pkg::RAMP_W-1:0]   slowdown_reg, slowdown_next;
    logic [tps_pkg::JOINT_W-1:0]  joint_total_reg, joint_total_next;
    logic                         result_valid_reg, result_valid_next;

    logic [tps_pkg::RAMP_W-1:0]   rem_reg, rem_next;
    logic [tps_pkg::FACTOR_W-1:0] quo_reg, quo_next;
    logic [tps_pkg::RAMP_W-1:0]   mul_n_reg, mul_n_next;
    logic [tps_pkg::RAMP_W-1:0]   div_d_reg, div_d_next;
    logic [tps_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic                         fault_reg, fault_next;
    logic                         speed_job_reg, speed_job_next;

    tps_pkg::run_t                out_run_reg, out_run_next;
    tps_pkg::reply_t              out_reply_reg, out_reply_next;
    logic [tps_pkg::FACTOR_W-1:0] out_factor_reg, out_factor_next;
    logic [tps_pkg::INDEX_W-1:0]  out_index_reg, out_index_next;
    logic                         out_drive_reg, out_drive_next;

    logic                         item_take;
    logic                         result_free;
    logic [tps_pkg::ACC_W:0]      acc_sum;
    logic [tps_pkg::ACC_W-1:0]    acc_add;
    logic [tps_pkg::RAMP_W-1:0]   ramp_d;
    logic [tps_pkg::RAMP_W-1:0]   ramp_inc;
    logic [tps_pkg::RAMP_W-1:0]   ramp_r;
    logic [tps_pkg::RAMP_W-1:0]   ramp_n;
    logic [tps_pkg::ACC_W:0]      mul_sum;
    logic [tps_pkg::RAMP_W:0]     div_trial;
    logic [tps_pkg::RAMP_W:0]     div_diff;
    logic                         div_ge;
    logic [tps_pkg::INDEX_W-1:0]  last_point;
    logic [tps_pkg::POINT_W-1:0]  acc_point;
    logic                         at_last;
    logic [tps_pkg::INDEX_W-1:0]  tick_index;
    logic [tps_pkg::POINT_W-1:0]  load_len;

    assign item_take   = item_valid && !item_stall;
    assign result_free = !result_valid_reg || !result_stall;

    assign acc_sum  = {1'b0, acc_reg} + {{(tps_pkg::ACC_W + 1 - tps_pkg::FACTOR_W){1'b0}},
                      factor_reg};
    assign acc_add  = acc_sum[tps_pkg::ACC_W] ? {tps_pkg::ACC_W{1'b1}}
                                              : acc_sum[tps_pkg::ACC_W-1:0];
    assign ramp_d   = (slowdown_reg == '0) ? 16'd1 : slowdown_reg;
    assign ramp_inc = (ramp_reg == '1) ? ramp_reg : ramp_reg + 16'd1;
    assign ramp_r   = (ramp_inc < ramp_d) ? ramp_inc : ramp_d;
    assign ramp_n   = (run_reg == tps_pkg::RUN_PAUSING) ? ramp_d - ramp_r : ramp_r;

    assign mul_sum   = {rem_reg[tps_pkg::RAMP_W-2:0], quo_reg, 1'b0}
                     + (mul_n_reg[tps_pkg::RAMP_W-1]
                        ? {{(tps_pkg::ACC_W + 1 - tps_pkg::FACTOR_W){1'b0}}, saved_reg}
                        : '0);
    assign div_trial = {rem_reg, quo_reg[tps_pkg::FACTOR_W-1]};
    assign div_ge    = div_trial >= {1'b0, div_d_reg};
    assign div_diff  = div_trial - {1'b0, div_d_reg};

    assign last_point = (active_len_reg == '0) ? '0
                      : tps_pkg::INDEX_W'(active_len_reg - 17'd1);
    assign acc_point  = acc_reg[tps_pkg::ACC_W-1:tps_pkg::INDEX_W];
    assign at_last    = acc_point >= {1'b0, last_point};
    assign tick_index = at_last ? last_point : acc_point[tps_pkg::INDEX_W-1:0];
    assign load_len   = (point_count > tps_pkg::POINT_W'(tps_pkg::MAX_POINTS))
                      ? tps_pkg::POINT_W'(tps_pkg::MAX_POINTS) : point_count;

    assign item_stall   = (state_reg != tps_pkg::SEQ_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign run_state    = out_run_reg;
    assign speed_factor = out_factor_reg;
    assign point_index  = out_index_reg;
    assign reply_code   = out_reply_reg;
    assign drive_enable = out_drive_reg;

    always_comb
    begin
        state_next        = state_reg;
        run_next          = run_reg;
        reply_next        = reply_reg;
        factor_next       = factor_reg;
        saved_next        = saved_reg;
        acc_next          = acc_reg;
        ramp_next         = ramp_reg;
        active_len_next   = active_len_reg;
        loaded_len_next   = loaded_len_reg;
        index_next        = index_reg;
        slowdown_next     = slowdown_reg;
        joint_total_next  = joint_total_reg;
        result_valid_next = result_valid_reg && result_stall;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        mul_n_next        = mul_n_reg;
        div_d_next        = div_d_reg;
        cnt_next          = cnt_reg;
        fault_next        = fault_reg;
        speed_job_next    = speed_job_reg;
        out_run_next      = out_run_reg;
        out_reply_next    = out_reply_reg;
        out_factor_next   = out_factor_reg;
        out_index_next    = out_index_reg;
        out_drive_next    = out_drive_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (tps_pkg::cfg_t'(cfg_index))
                tps_pkg::CFG_SLOWDOWN: slowdown_next    = cfg_data;
                tps_pkg::CFG_JOINTS:   joint_total_next = cfg_data[tps_pkg::JOINT_W-1:0];
                default:               slowdown_next    = slowdown_reg;
            endcase
        end

        case (state_reg)
            tps_pkg::SEQ_IDLE:
            begin
                if (item_take)
                begin
                    reply_next     = tps_pkg::REPLY_OK;
                    fault_next     = joint_fault;
                    speed_job_next = 1'b0;
                    state_next     = tps_pkg::SEQ_EMIT;
                    case (tps_pkg::mode_t'(mode))
                        tps_pkg::MODE_TICK:
                        begin
                            acc_next   = acc_add;
                            state_next = tps_pkg::SEQ_TICK_END;
                            if (run_reg == tps_pkg::RUN_PAUSING ||
                                run_reg == tps_pkg::RUN_RESUMING)
                            begin
                                ramp_next = ramp_inc;
                                if (run_reg == tps_pkg::RUN_RESUMING || factor_reg != '0)
                                begin
                                    rem_next   = '0;
                                    quo_next   = '0;
                                    mul_n_next = ramp_n;
                                    div_d_next = ramp_d;
                                    cnt_next   = tps_pkg::MUL_LAST_STEP;
                                    state_next = tps_pkg::SEQ_MUL;
                                end
                            end
                        end
                        tps_pkg::MODE_START:
                        begin
                            run_next    = tps_pkg::RUN_RUNNING;
                            acc_next    = '0;
                            factor_next = tps_pkg::ONE_FACTOR;
                            saved_next  = tps_pkg::ONE_FACTOR;
                        end
                        tps_pkg::MODE_STOP, tps_pkg::MODE_SECURITY:
                        begin
                            run_next    = tps_pkg::RUN_STOPPED;
                            factor_next = '0;
                            if (factor_reg != '0)
                                saved_next = factor_reg;
                        end
                        tps_pkg::MODE_RESUME:
                        begin
                            if (run_reg == tps_pkg::RUN_PAUSING)
                            begin
                                run_next  = tps_pkg::RUN_RESUMING;
                                ramp_next = '0;
                            end
                            else
                                reply_next = tps_pkg::REPLY_RESUME_REFUSED;
                        end
                        tps_pkg::MODE_PAUSE:
                        begin
                            if (run_reg == tps_pkg::RUN_RUNNING)
                            begin
                                run_next  = tps_pkg::RUN_PAUSING;
                                ramp_next = '0;
                                if (factor_reg != '0)
                                    saved_next = factor_reg;
                            end
                            else
                                reply_next = tps_pkg::REPLY_PAUSE_REFUSED;
                        end
                        tps_pkg::MODE_EXECUTE:
                        begin
                            if (loaded_len_reg == '0)
                                reply_next = tps_pkg::REPLY_NO_TRAJECTORY;
                            else if (!start_in_place)
                                reply_next = tps_pkg::REPLY_NOT_IN_PLACE;
                            else
                            begin
                                active_len_next = loaded_len_reg;
                                run_next        = tps_pkg::RUN_RUNNING;
                                factor_next     = saved_reg;
                                acc_next        = '0;
                            end
                        end
                        tps_pkg::MODE_SPEED:
                        begin
                            speed_job_next = 1'b1;
                            rem_next       = {{(tps_pkg::RAMP_W - tps_pkg::PCT_W + 2){1'b0}},
                                              speed_percent[tps_pkg::PCT_W-1:2]};
                            quo_next       = {speed_percent[1:0],
                                              {(tps_pkg::FACTOR_W - 2){1'b0}}};
                            div_d_next     = tps_pkg::SPEED_DIVISOR;
                            cnt_next       = tps_pkg::DIV_LAST_STEP;
                            state_next     = tps_pkg::SEQ_DIV;
                        end
                        tps_pkg::MODE_LOAD:
                        begin
                            if (joint_count == joint_total_reg)
                                loaded_len_next = load_len;
                        end
                        default:
                            reply_next = tps_pkg::REPLY_UNKNOWN;
                    endcase
                end
            end
            tps_pkg::SEQ_MUL:
            begin
                rem_next   = mul_sum[tps_pkg::ACC_W:tps_pkg::FACTOR_W];
                quo_next   = mul_sum[tps_pkg::FACTOR_W-1:0];
                mul_n_next = {mul_n_reg[tps_pkg::RAMP_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = tps_pkg::DIV_LAST_STEP;
                    state_next = tps_pkg::SEQ_DIV;
                end
            end
            tps_pkg::SEQ_DIV:
            begin
                rem_next = div_ge ? div_diff[tps_pkg::RAMP_W-1:0]
                                  : div_trial[tps_pkg::RAMP_W-1:0];
                quo_next = {quo_reg[tps_pkg::FACTOR_W-2:0], div_ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                    state_next = tps_pkg::SEQ_APPLY;
            end
            tps_pkg::SEQ_APPLY:
            begin
                if (speed_job_reg)
                begin
                    if (run_reg == tps_pkg::RUN_RUNNING)
                        factor_next = quo_reg;
                    else
                        saved_next = quo_reg;
                    state_next = tps_pkg::SEQ_EMIT;
                end
                else
                begin
                    factor_next = quo_reg;
                    if (run_reg == tps_pkg::RUN_RESUMING && quo_reg == saved_reg)
                        run_next = tps_pkg::RUN_RUNNING;
                    state_next = tps_pkg::SEQ_TICK_END;
                end
            end
            tps_pkg::SEQ_TICK_END:
            begin
                if (run_reg == tps_pkg::RUN_RUNNING && fault_reg)
                begin
                    run_next    = tps_pkg::RUN_STOPPED;
                    factor_next = '0;
                    if (factor_reg != '0)
                        saved_next = factor_reg;
                end
                index_next = tick_index;
                if (at_last && factor_next != '0)
                begin
                    if (run_next != tps_pkg::RUN_PAUSING)
                    begin
                        run_next   = tps_pkg::RUN_PAUSING;
                        ramp_next  = '0;
                        saved_next = factor_next;
                    end
                    factor_next = '0;
                end
                state_next = tps_pkg::SEQ_EMIT;
            end
            tps_pkg::SEQ_EMIT:
            begin
                if (result_free)
                begin
                    result_valid_next = 1'b1;
                    out_run_next      = run_reg;
                    out_reply_next    = reply_reg;
                    out_factor_next   = factor_reg;
                    out_index_next    = index_reg;
                    out_drive_next    = (run_reg != tps_pkg::RUN_STOPPED);
                    state_next        = tps_pkg::SEQ_IDLE;
                end
            end
            default:
                state_next = tps_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tps_pkg::SEQ_IDLE;
            run_reg          <= tps_pkg::RUN_RUNNING;
            factor_reg       <= '0;
            saved_reg        <= tps_pkg::ONE_FACTOR;
            acc_reg          <= '0;
            ramp_reg         <= '0;
            active_len_reg   <= 17'd1;
            loaded_len_reg   <= '0;
            index_reg        <= '0;
            slowdown_reg     <= tps_pkg::SLOWDOWN_RESET;
            joint_total_reg  <= tps_pkg::JOINTS_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            run_reg          <= run_next;
            factor_reg       <= factor_next;
            saved_reg        <= saved_next;
            acc_reg          <= acc_next;
            ramp_reg         <= ramp_next;
            active_len_reg   <= active_len_next;
            loaded_len_reg   <= loaded_len_next;
            index_reg        <= index_next;
            slowdown_reg     <= slowdown_next;
            joint_total_reg  <= joint_total_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reply_reg      <= reply_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        mul_n_reg      <= mul_n_next;
        div_d_reg      <= div_d_next;
        cnt_reg        <= cnt_next;
        fault_reg      <= fault_next;
        speed_job_reg  <= speed_job_next;
        out_run_reg    <= out_run_next;
        out_reply_reg  <= out_reply_next;
        out_factor_reg <= out_factor_next;
        out_index_reg  <= out_index_next;
        out_drive_reg  <= out_drive_next;
    end

endmodule

[rtl/tps_checker.sv]
// Port-level checker for the trajectory playback sequencer, bound to its top level.
// Depends on tps_pkg and trajectory_playback_sequencer_core.
module tps_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_stall,
    input logic                           result_valid,
    input logic                           result_stall,
    input logic [1:0]                     run_state,
    input logic [tps_pkg::FACTOR_W-1:0]   speed_factor,
    input logic [tps_pkg::INDEX_W-1:0]    point_index,
    input logic [2:0]                     reply_code,
    input logic                           drive_enable
);

    // Hold a stalled result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(run_state) &&
        $stable(speed_factor) && $stable(point_index) && $stable(reply_code))
    else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
    else $error("input taken while an item is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> drive_enable == (run_state != 2'(tps_pkg::RUN_STOPPED)))
    else $error("drive enable disagrees with run state");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && run_state == 2'(tps_pkg::RUN_STOPPED) |-> speed_factor == '0)
    else $error("nonzero speed factor while stopped");

endmodule

bind trajectory_playback_sequencer_core tps_checker u_tps_checker (.*);
